FILE: design/verlet_spring_tip_step_core_defines.svh
// assertion macros used by the checker file
`ifndef VERLET_SPRING_TIP_STEP_CORE_DEFINES_SVH
`define VERLET_SPRING_TIP_STEP_CORE_DEFINES_SVH

// same-cycle implication
`define VSPT_AST_NOW(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("vspt assertion failed");

// next-cycle implication
`define VSPT_AST_NXT(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("vspt assertion failed");

`endif

FILE: design/vspt_pkg.sv
package vspt_pkg;

	localparam int BONE_SLOTS = 64;
	localparam int SLOT_W     = 6;
	localparam int FRAC_BITS  = 16;
	localparam int TIP_W      = 32;
	localparam int GAIN_W     = 17;
	localparam int PROD_W     = 59;
	localparam int T_W        = 40;
	localparam int DIR_W      = 44;
	localparam int STORE_W    = 6 * TIP_W;
	localparam int IDX_W      = 2;

	localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(1) << FRAC_BITS;

	typedef enum logic [IDX_W-1:0] {
		REG_GRAV_X = 2'd0,
		REG_GRAV_Y = 2'd1,
		REG_GRAV_Z = 2'd2
	} reg_idx_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_VEL,
		S_PULL,
		S_SPR,
		S_DIR,
		S_MAX,
		S_NORM,
		S_SQ,
		S_SQRT,
		S_NUM,
		S_DIV,
		S_RES,
		S_WRITE
	} state_t;

	function automatic logic [DIR_W-1:0] mag_f(input logic signed [DIR_W-1:0] v);
		logic [DIR_W-1:0] r;
		r = v[DIR_W-1] ? DIR_W'(-v) : DIR_W'(v);
		return r;
	endfunction

endpackage

FILE: design/vspt_ifs.sv
interface vspt_req_if;
	logic                 valid;
	logic                 ready;
	logic [5:0]           bone_slot;
	logic                 init_flag;
	logic signed [31:0]   rest_x;
	logic signed [31:0]   rest_y;
	logic signed [31:0]   rest_z;
	logic signed [31:0]   head_x;
	logic signed [31:0]   head_y;
	logic signed [31:0]   head_z;
	logic [30:0]          bone_len;
	logic [17:0]          spring_gain;
	logic [17:0]          damp_gain;

	modport source(output valid, bone_slot, init_flag, rest_x, rest_y, rest_z,
		head_x, head_y, head_z, bone_len, spring_gain, damp_gain, input ready);
	modport sink(input valid, bone_slot, init_flag, rest_x, rest_y, rest_z,
		head_x, head_y, head_z, bone_len, spring_gain, damp_gain, output ready);
endinterface

interface vspt_rsp_if;
	logic               valid;
	logic               ready;
	logic [5:0]         out_slot;
	logic signed [31:0] tip_x;
	logic signed [31:0] tip_y;
	logic signed [31:0] tip_z;

	modport source(output valid, out_slot, tip_x, tip_y, tip_z, input ready);
	modport sink(input valid, out_slot, tip_x, tip_y, tip_z, output ready);
endinterface

interface vspt_cfg_if;
	logic               valid;
	logic               ready;
	logic [1:0]         index;
	logic signed [31:0] data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

FILE: design/vspt_ram.sv
module vspt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata_q
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end
endmodule

FILE: design/verlet_spring_tip_step_core.sv
// Verlet spring tip core: one jiggle-bone step per transaction.
// req carries slot, init flag, rest tip, head, bone length and gains; rsp
// returns slot and new tip. cfg writes gravity*dt^2 registers (index 0..2,
// other indexes ignored); cfg.ready is always high.
// Tip history (current and previous) of all slots sits in one RAM with a
// registered read, read once and written back once per item.
// Items are handled one at a time; req.ready is high only while idle.
// An init item goes straight to write-back. A step item's time grows with the
// n = 0..30 one-bit normalize shifts and is set by the 32-step square root and the
// three 32-step divisions sharing one iterative unit. A step whose tip lands
// exactly on the head skips the projection.
// A finished result waits in the rsp output register; the core accepts the
// next item meanwhile and only holds its write-back while rsp stays stalled.
// Reset clears control and gravity registers; RAM content is undefined until
// a slot is initialized.
module verlet_spring_tip_step_core (
	input  logic        clk,
	input  logic        arst_n,
	vspt_req_if.sink    req,
	vspt_rsp_if.source  rsp,
	vspt_cfg_if.sink    cfg
);
	localparam int TW = vspt_pkg::TIP_W;
	localparam int DW = vspt_pkg::DIR_W;
	localparam int PW = vspt_pkg::PROD_W;

	vspt_pkg::state_t state_q, state_d;

	logic [1:0]                    ax_q;
	logic [vspt_pkg::SLOT_W-1:0]   slot_q;
	logic                          init_q;
	logic signed [TW-1:0]          rest_q [3];
	logic signed [TW-1:0]          head_q [3];
	logic signed [TW-1:0]          grav_q [3];
	logic signed [TW-1:0]          res_q  [3];
	logic signed [DW-1:0]          dir_q  [3];
	logic [30:0]                   len_q;
	logic [vspt_pkg::GAIN_W-1:0]   spring_q, keep_q;
	logic signed [PW-1:0]          prod_q;
	logic signed [vspt_pkg::T_W-1:0] t_q;
	logic [DW-1:0]                 m_q;
	logic [63:0]                   sq_q;
	logic [31:0]                   root_q;
	logic [34:0]                   rem_q;
	logic [4:0]                    cnt_q;
	logic [63:0]                   num_q;
	logic [31:0]                   drem_q;
	logic [31:0]                   quo_q;

	logic                          out_valid_q;
	logic [vspt_pkg::SLOT_W-1:0]   out_slot_q;
	logic signed [TW-1:0]          out_tip_q [3];

	logic [vspt_pkg::STORE_W-1:0]  rd;
	logic                          ram_we, ram_re;
	logic [vspt_pkg::STORE_W-1:0]  ram_wdata;

	logic in_acc, out_free;
	logic [vspt_pkg::GAIN_W-1:0] spring_c, damp_c;

	assign in_acc   = req.valid && req.ready;
	assign out_free = !out_valid_q || rsp.ready;

	always_comb begin
		spring_c = (req.spring_gain > 18'(vspt_pkg::GAIN_ONE)) ? vspt_pkg::GAIN_ONE
			: req.spring_gain[vspt_pkg::GAIN_W-1:0];
		damp_c   = (req.damp_gain > 18'(vspt_pkg::GAIN_ONE)) ? vspt_pkg::GAIN_ONE
			: req.damp_gain[vspt_pkg::GAIN_W-1:0];
	end

	// per-axis datapath
	logic signed [TW-1:0]   cur_a, prev_a, rest_a, head_a;
	logic signed [TW:0]     diff_c;
	logic signed [50:0]     vel_prod;
	logic signed [40:0]     rt_c;
	logic signed [57:0]     spr_prod;
	logic signed [PW-1:0]   rnd_c;
	logic signed [vspt_pkg::T_W-1:0] t_c;
	logic signed [DW-1:0]   dir_c;
	logic [DW-1:0]          mag_a, mag0, mag1, mag2, max_c;
	logic [63:0]            sqr_c, num_c;
	logic [34:0]            rem_n, trial;
	logic [32:0]            dr_n;
	logic signed [33:0]     sum_c;
	logic signed [TW-1:0]   sat_c;

	always_comb begin
		cur_a    = $signed(rd[3*TW + 32*ax_q +: 32]);
		prev_a   = $signed(rd[32*ax_q +: 32]);
		rest_a   = rest_q[ax_q];
		head_a   = head_q[ax_q];
		diff_c   = 33'(cur_a) - 33'(prev_a);
		vel_prod = diff_c * $signed({1'b0, keep_q});
		rt_c     = 41'(rest_a) - 41'(t_q);
		spr_prod = rt_c * $signed({1'b0, spring_q});
		rnd_c    = (prod_q + (PW'(1) <<< (vspt_pkg::FRAC_BITS - 1))) >>> vspt_pkg::FRAC_BITS;
		t_c      = 40'(cur_a) + $signed(rnd_c[39:0]) + 40'(grav_q[ax_q]);
		dir_c    = DW'(t_q) + $signed(rnd_c[DW-1:0]) - DW'(head_a);
		mag_a    = vspt_pkg::mag_f(dir_q[ax_q]);
		mag0     = vspt_pkg::mag_f(dir_q[0]);
		mag1     = vspt_pkg::mag_f(dir_q[1]);
		mag2     = vspt_pkg::mag_f(dir_q[2]);
		max_c    = (mag0 > mag1) ? mag0 : mag1;
		max_c    = (mag2 > max_c) ? mag2 : max_c;
		sqr_c    = {32'd0, mag_a[31:0]} * {32'd0, mag_a[31:0]};
		num_c    = {32'd0, mag_a[31:0]} * {33'd0, len_q} + {33'd0, root_q[31:1]};
		rem_n    = {rem_q[32:0], sq_q[63:62]};
		trial    = {1'b0, root_q, 2'b01};
		dr_n     = {drem_q, num_q[31]};
		sum_c    = 34'(head_a) + (dir_q[ax_q][DW-1] ? -$signed({2'b00, quo_q})
			: $signed({2'b00, quo_q}));
		if (sum_c > 34'sd2147483647) begin
			sat_c = 32'sh7fffffff;
		end else if (sum_c < -34'sd2147483648) begin
			sat_c = 32'sh80000000;
		end else begin
			sat_c = sum_c[31:0];
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			vspt_pkg::S_IDLE:  if (in_acc) state_d = req.init_flag ? vspt_pkg::S_WRITE
				: vspt_pkg::S_VEL;
			vspt_pkg::S_VEL:   state_d = vspt_pkg::S_PULL;
			vspt_pkg::S_PULL:  state_d = vspt_pkg::S_SPR;
			vspt_pkg::S_SPR:   state_d = vspt_pkg::S_DIR;
			vspt_pkg::S_DIR:   state_d = (ax_q == 2'd2) ? vspt_pkg::S_MAX : vspt_pkg::S_VEL;
			vspt_pkg::S_MAX:   state_d = (max_c == '0) ? vspt_pkg::S_WRITE : vspt_pkg::S_NORM;
			vspt_pkg::S_NORM:  if (m_q < (DW'(1) << 31) && m_q >= (DW'(1) << 30))
				state_d = vspt_pkg::S_SQ;
			vspt_pkg::S_SQ:    if (ax_q == 2'd2) state_d = vspt_pkg::S_SQRT;
			vspt_pkg::S_SQRT:  if (cnt_q == '0) state_d = vspt_pkg::S_NUM;
			vspt_pkg::S_NUM:   state_d = vspt_pkg::S_DIV;
			vspt_pkg::S_DIV:   if (cnt_q == '0) state_d = vspt_pkg::S_RES;
			vspt_pkg::S_RES:   state_d = (ax_q == 2'd2) ? vspt_pkg::S_WRITE : vspt_pkg::S_NUM;
			vspt_pkg::S_WRITE: if (out_free) state_d = vspt_pkg::S_IDLE;
			default:           state_d = vspt_pkg::S_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		req.ready = (state_q == vspt_pkg::S_IDLE);
		cfg.ready = 1'b1;
		ram_re    = in_acc;
		ram_we    = (state_q == vspt_pkg::S_WRITE) && out_free;
		ram_wdata = {res_q[2], res_q[1], res_q[0],
			init_q ? {res_q[2], res_q[1], res_q[0]} : rd[vspt_pkg::STORE_W-1:3*TW]};
	end

	vspt_ram #(
		.WIDTH(vspt_pkg::STORE_W),
		.DEPTH(vspt_pkg::BONE_SLOTS)
	) u_ram (
		.clk    (clk),
		.we     (ram_we),
		.waddr  (slot_q),
		.wdata  (ram_wdata),
		.re     (ram_re),
		.raddr  (req.bone_slot),
		.rdata_q(rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= vspt_pkg::S_IDLE;
			out_valid_q <= 1'b0;
			ax_q        <= '0;
			cnt_q       <= '0;
			grav_q[0]   <= '0;
			grav_q[1]   <= '0;
			grav_q[2]   <= '0;
		end else begin
			state_q     <= state_d;
			out_valid_q <= ram_we || (out_valid_q && !rsp.ready);
			if (cfg.valid && cfg.ready) begin
				if (cfg.index == vspt_pkg::REG_GRAV_X) grav_q[0] <= cfg.data;
				if (cfg.index == vspt_pkg::REG_GRAV_Y) grav_q[1] <= cfg.data;
				if (cfg.index == vspt_pkg::REG_GRAV_Z) grav_q[2] <= cfg.data;
			end
			case (state_q)
				vspt_pkg::S_IDLE: ax_q <= '0;
				vspt_pkg::S_DIR:  ax_q <= (ax_q == 2'd2) ? 2'd0 : ax_q + 2'd1;
				vspt_pkg::S_SQ: begin
					ax_q  <= (ax_q == 2'd2) ? 2'd0 : ax_q + 2'd1;
					cnt_q <= 5'd31;
				end
				vspt_pkg::S_SQRT: cnt_q <= cnt_q - 5'd1;
				vspt_pkg::S_NUM:  cnt_q <= 5'd31;
				vspt_pkg::S_DIV:  cnt_q <= cnt_q - 5'd1;
				vspt_pkg::S_RES:  ax_q <= (ax_q == 2'd2) ? 2'd0 : ax_q + 2'd1;
				default: ;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			vspt_pkg::S_IDLE: if (in_acc) begin
				slot_q    <= req.bone_slot;
				init_q    <= req.init_flag;
				rest_q[0] <= req.rest_x;
				rest_q[1] <= req.rest_y;
				rest_q[2] <= req.rest_z;
				res_q[0]  <= req.rest_x;
				res_q[1]  <= req.rest_y;
				res_q[2]  <= req.rest_z;
				head_q[0] <= req.head_x;
				head_q[1] <= req.head_y;
				head_q[2] <= req.head_z;
				len_q     <= req.bone_len;
				spring_q  <= spring_c;
				keep_q    <= vspt_pkg::GAIN_ONE - damp_c;
			end
			vspt_pkg::S_VEL:  prod_q <= PW'(vel_prod);
			vspt_pkg::S_PULL: t_q <= t_c;
			vspt_pkg::S_SPR:  prod_q <= PW'(spr_prod);
			vspt_pkg::S_DIR:  dir_q[ax_q] <= dir_c;
			vspt_pkg::S_MAX: begin
				m_q  <= max_c;
				sq_q <= '0;
			end
			vspt_pkg::S_NORM: begin
				// tracked magnitude steers the shift, as floor shifts may differ
				if (m_q >= (DW'(1) << 31)) begin
					m_q      <= m_q >> 1;
					dir_q[0] <= dir_q[0] >>> 1;
					dir_q[1] <= dir_q[1] >>> 1;
					dir_q[2] <= dir_q[2] >>> 1;
				end else if (m_q < (DW'(1) << 30)) begin
					m_q      <= m_q << 1;
					dir_q[0] <= dir_q[0] <<< 1;
					dir_q[1] <= dir_q[1] <<< 1;
					dir_q[2] <= dir_q[2] <<< 1;
				end
			end
			vspt_pkg::S_SQ: begin
				sq_q   <= sq_q + sqr_c;
				root_q <= '0;
				rem_q  <= '0;
			end
			vspt_pkg::S_SQRT: begin
				sq_q <= sq_q << 2;
				if (rem_n >= trial) begin
					rem_q  <= rem_n - trial;
					root_q <= {root_q[30:0], 1'b1};
				end else begin
					rem_q  <= rem_n;
					root_q <= {root_q[30:0], 1'b0};
				end
			end
			vspt_pkg::S_NUM: begin
				// quotient fits 32 bits, so upper half is already below divisor
				drem_q <= num_c[63:32];
				num_q  <= num_c;
				quo_q  <= '0;
			end
			vspt_pkg::S_DIV: begin
				num_q <= num_q << 1;
				if (dr_n >= {1'b0, root_q}) begin
					drem_q <= 32'(dr_n - {1'b0, root_q});
					quo_q  <= {quo_q[30:0], 1'b1};
				end else begin
					drem_q <= dr_n[31:0];
					quo_q  <= {quo_q[30:0], 1'b0};
				end
			end
			vspt_pkg::S_RES: res_q[ax_q] <= sat_c;
			vspt_pkg::S_WRITE: if (out_free) begin
				out_slot_q   <= slot_q;
				out_tip_q[0] <= res_q[0];
				out_tip_q[1] <= res_q[1];
				out_tip_q[2] <= res_q[2];
			end
			default: ;
		endcase
	end

	assign rsp.valid    = out_valid_q;
	assign rsp.out_slot = out_slot_q;
	assign rsp.tip_x    = out_tip_q[0];
	assign rsp.tip_y    = out_tip_q[1];
	assign rsp.tip_z    = out_tip_q[2];

endmodule

FILE: design/vspt_checker.sv
`include "verlet_spring_tip_step_core_defines.svh"

module vspt_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [5:0] out_slot,
	input logic       cfg_valid,
	input logic       cfg_ready
);
	// one item in flight: ready drops right after a transaction
	`VSPT_AST_NXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
	// config writes are never stalled
	`VSPT_AST_NOW(a_cfg_ready, cfg_valid, cfg_ready)
	`VSPT_AST_NXT(a_out_hold, out_valid && !out_ready, out_valid)
	`VSPT_AST_NXT(a_slot_hold, out_valid && !out_ready, $stable(out_slot))
endmodule

bind verlet_spring_tip_step_core vspt_checker u_vspt_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (req.valid),
	.in_ready (req.ready),
	.out_valid(rsp.valid),
	.out_ready(rsp.ready),
	.out_slot (rsp.out_slot),
	.cfg_valid(cfg.valid),
	.cfg_ready(cfg.ready)
);
